// ===== rtl/core/rau_pkg.sv =====
// package for the rational arithmetic unit: request codes, payload structs, sequencer states
package rau_pkg;

  localparam int unsigned NumW = 16;
  localparam int unsigned DenW = 15;
  localparam int unsigned ResNumW = 32;
  localparam int unsigned ResDenW = 31;
  localparam int unsigned MagW = 33;

  typedef enum logic [3:0] {
    REQ_ADD = 4'd0,
    REQ_SUB = 4'd1,
    REQ_MUL = 4'd2,
    REQ_DIV = 4'd3,
    REQ_LT  = 4'd4,
    REQ_LE  = 4'd5,
    REQ_GT  = 4'd6,
    REQ_GE  = 4'd7,
    REQ_EQ  = 4'd8,
    REQ_NE  = 4'd9
  } req_type_e;

  typedef struct packed {
    logic [3:0]          req_type;
    logic signed [15:0]  a_num;
    logic [14:0]         a_den;
    logic signed [15:0]  b_num;
    logic [14:0]         b_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0]  res_num;
    logic [30:0]         res_den;
    logic                cmp_true;
    logic                div_zero;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMB,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/core/rational_arithmetic_unit.sv =====
// rational arithmetic unit top level: sequencer around a shared multiplier, gcd and divider
//
// Takes one request at a time: two fractions (signed numerator over positive
// denominator) and an operation code. Add, subtract, multiply and divide form the
// cross products on a single shared 17x17 signed multiplier (one product per
// cycle), then reduce by the greatest common divisor found with a binary gcd
// (one shift or subtract-and-shift step per cycle on 33-bit magnitudes), then
// divide numerator and denominator by that divisor with a restoring divider, one
// quotient bit per cycle. A comparison or a zero/error result skips the gcd loop
// and the bit-serial divider, which only a reduced arithmetic result runs
// through. stall_o is high while a request is in work. A finished response sits
// in an output register until taken, so the next request can start meanwhile; a
// zero numerator is not reduced and keeps the raw denominator, a zero denominator
// flags div_zero with zero fields, and unused codes give an all-zero response.
module rational_arithmetic_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  rau_pkg::req_t  req_i,
  output logic           valid_o,
  input  logic           stall_i,
  output rau_pkg::rsp_t  rsp_o
);

  localparam int unsigned MW = rau_pkg::MagW;

  rau_pkg::state_e state_q, state_d;
  rau_pkg::req_t   req_q;
  logic signed [33:0] p1_q, p2_q;        // cross products
  logic signed [34:0] n_q;               // raw numerator
  logic signed [33:0] d_q;               // raw denominator
  logic [MW-1:0] un_q, ud_q;             // magnitudes kept for the final divides
  logic [MW-1:0] gx_q, gy_q;             // gcd working pair
  logic [5:0]    gk_q;                   // shared power of two
  logic [MW-1:0] g_q;                    // divisor
  logic [MW-1:0] quo_q;
  logic [MW:0]   rem_q;
  logic [5:0]    cnt_q;
  logic [MW-1:0] qn_q;
  logic          neg_q;
  logic          valid_q;
  rau_pkg::rsp_t rsp_q;                  // response being built
  rau_pkg::rsp_t out_q;                  // response on offer

  // shared multiplier operands
  logic signed [16:0] ma, mb;
  logic signed [33:0] prod;
  logic [MW:0] trial;
  logic [MW-1:0] dividend;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      rau_pkg::ST_MUL1: begin
        ma = 17'(req_q.a_num);
        mb = (req_q.req_type == rau_pkg::REQ_MUL) ? 17'(req_q.b_num) : $signed({2'b0, req_q.b_den});
      end
      rau_pkg::ST_MUL2: begin
        ma = $signed({2'b0, req_q.a_den});
        mb = (req_q.req_type == rau_pkg::REQ_MUL) ? $signed({2'b0, req_q.b_den})
                                                  : 17'(req_q.b_num);
      end
      rau_pkg::ST_MUL3: begin
        // denominator product for add and subtract
        ma = $signed({2'b0, req_q.a_den});
        mb = $signed({2'b0, req_q.b_den});
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;
  assign dividend = (state_q == rau_pkg::ST_DIVN) ? un_q : ud_q;
  assign trial = {rem_q[MW-1:0], dividend[6'(MW-1) - cnt_q]} - {1'b0, g_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rau_pkg::ST_IDLE:  if (valid_i) state_d = rau_pkg::ST_MUL1;
      rau_pkg::ST_MUL1:  state_d = rau_pkg::ST_MUL2;
      rau_pkg::ST_MUL2:  state_d = rau_pkg::ST_MUL3;
      rau_pkg::ST_MUL3:  state_d = rau_pkg::ST_COMB;
      rau_pkg::ST_COMB:  state_d = rau_pkg::ST_GCD;
      rau_pkg::ST_GCD:   if (gx_q == gy_q || gy_q == '0) state_d = rau_pkg::ST_DIVN;
      rau_pkg::ST_DIVN:  if (cnt_q == 6'(MW-1)) state_d = rau_pkg::ST_DIVD;
      rau_pkg::ST_DIVD:  if (cnt_q == 6'(MW-1)) state_d = rau_pkg::ST_DONE;
      rau_pkg::ST_DONE:  if (!valid_q) state_d = rau_pkg::ST_IDLE;
      default:           state_d = rau_pkg::ST_IDLE;
    endcase
    if (state_q == rau_pkg::ST_COMB) begin
      if (req_q.req_type > rau_pkg::REQ_DIV || d_q == '0 || n_q == '0)
        state_d = rau_pkg::ST_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::ST_IDLE;
      valid_q <= 1'b0;
      out_q   <= '0;
    end else begin
      state_q <= state_d;
      if (valid_q && !stall_i) valid_q <= 1'b0;
      if (state_q == rau_pkg::ST_DONE && !valid_q) begin
        valid_q <= 1'b1;
        out_q   <= rsp_q;
      end
    end
  end

  logic cmp_res;
  logic signed [33:0] lhs, rhs;
  assign lhs = p1_q;
  assign rhs = p2_q;
  always_comb begin
    case (req_q.req_type)
      rau_pkg::REQ_LT: cmp_res = lhs < rhs;
      rau_pkg::REQ_LE: cmp_res = lhs <= rhs;
      rau_pkg::REQ_GT: cmp_res = lhs > rhs;
      rau_pkg::REQ_GE: cmp_res = lhs >= rhs;
      rau_pkg::REQ_EQ: cmp_res = lhs == rhs;
      rau_pkg::REQ_NE: cmp_res = lhs != rhs;
      default:         cmp_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rau_pkg::ST_IDLE: if (valid_i) req_q <= req_i;
      rau_pkg::ST_MUL1: p1_q <= prod;
      rau_pkg::ST_MUL2: p2_q <= prod;
      rau_pkg::ST_MUL3: begin
        // form raw numerator and denominator
        unique case (req_q.req_type)
          rau_pkg::REQ_ADD: begin
            n_q <= 35'(p1_q) + 35'(p2_q);
            d_q <= prod;
          end
          rau_pkg::REQ_SUB: begin
            n_q <= 35'(p1_q) - 35'(p2_q);
            d_q <= prod;
          end
          rau_pkg::REQ_MUL: begin
            n_q <= 35'(p1_q);
            d_q <= p2_q;
          end
          default: begin
            n_q <= 35'(p1_q);
            d_q <= p2_q;
          end
        endcase
      end
      rau_pkg::ST_COMB: begin
        un_q  <= n_q[34] ? MW'(-n_q) : MW'(n_q);
        ud_q  <= d_q[33] ? MW'(-d_q) : MW'(d_q);
        gx_q  <= n_q[34] ? MW'(-n_q) : MW'(n_q);
        gy_q  <= d_q[33] ? MW'(-d_q) : MW'(d_q);
        neg_q <= n_q[34] ^ d_q[33];
        gk_q  <= '0;
        if (req_q.req_type > rau_pkg::REQ_DIV) begin
          rsp_q <= {32'd0, 31'd0, (req_q.req_type <= rau_pkg::REQ_NE) & cmp_res, 1'b0};
        end else if (d_q == '0) begin
          rsp_q <= {32'd0, 31'd0, 1'b0, 1'b1};
        end else if (n_q == '0) begin
          rsp_q <= {32'd0, (d_q[33] ? 31'(-d_q) : 31'(d_q)), 2'b00};
        end else begin
          rsp_q <= '0;
        end
      end
      rau_pkg::ST_GCD: begin
        // binary gcd step
        if (gx_q == gy_q || gy_q == '0) begin
          g_q   <= gx_q << gk_q;
          cnt_q <= '0;
          rem_q <= '0;
        end else if (!gx_q[0] && !gy_q[0]) begin
          gx_q <= gx_q >> 1;
          gy_q <= gy_q >> 1;
          gk_q <= gk_q + 6'd1;
        end else if (!gx_q[0]) begin
          gx_q <= gx_q >> 1;
        end else if (!gy_q[0]) begin
          gy_q <= gy_q >> 1;
        end else if (gx_q > gy_q) begin
          gx_q <= (gx_q - gy_q) >> 1;
        end else begin
          gy_q <= (gy_q - gx_q) >> 1;
        end
      end
      rau_pkg::ST_DIVN, rau_pkg::ST_DIVD: begin
        // restoring division, one bit a cycle
        quo_q <= {quo_q[MW-2:0], ~trial[MW]};
        if (cnt_q == 6'(MW-1)) begin
          cnt_q <= '0;
          rem_q <= '0;
          if (state_q == rau_pkg::ST_DIVN) begin
            qn_q <= {quo_q[MW-2:0], ~trial[MW]};
          end else begin
            rsp_q <= {(neg_q ? -32'(qn_q) : 32'(qn_q)),
                      31'({quo_q[MW-2:0], ~trial[MW]}), 2'b00};
          end
        end else begin
          cnt_q <= cnt_q + 6'd1;
          rem_q <= trial[MW] ? {rem_q[MW-1:0], dividend[6'(MW-1) - cnt_q]} : trial;
        end
      end
      default: ;
    endcase
  end

  assign stall_o = (state_q != rau_pkg::ST_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = out_q;

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rau_pkg::ST_IDLE) |-> stall_o) else $error("busy without stall");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(rsp_o))) else $error("response dropped");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(rsp_o.cmp_true && rsp_o.div_zero)) else $error("flags both set");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> (state_q == rau_pkg::ST_MUL1)) else $error("request lost");
`endif

endmodule

// ===== tb/rational_arithmetic_unit_tb.sv =====
// testbench for the rational arithmetic unit: directed table plus random requests against a predictor
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;

  localparam int unsigned CycleLimit = 2000000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           valid_i = 1'b0;
  logic           stall_o;
  rau_pkg::req_t  req_i = '0;
  logic           valid_o;
  logic           stall_i = 1'b1;
  rau_pkg::rsp_t  rsp_o;

  rau_pkg::rsp_t  expected_rsp_q[$];
  int    mismatches = 0;
  int    cycles = 0;
  bit    hold_off = 1'b0;

  // directed row: request plus an optional typed-in response
  typedef struct {
    rau_pkg::req_t req;
    bit            typed;
    rau_pkg::rsp_t rsp;
  } vec_t;

  vec_t  dir_table[$];

  rational_arithmetic_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .req_i   (req_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .rsp_o   (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // euclid on magnitudes
  function automatic longint unsigned common_divisor(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // works out the reduced fraction or comparison flag for one request
  function automatic rau_pkg::rsp_t rational_result(rau_pkg::req_t r);
    rau_pkg::rsp_t   o;
    longint          an, ad, bn, bd, n, d, l, rr;
    longint unsigned un, ud, g;
    bit              neg;
    o  = '0;
    an = longint'(r.a_num);
    ad = longint'({1'b0, r.a_den});
    bn = longint'(r.b_num);
    bd = longint'({1'b0, r.b_den});
    l  = an * bd;
    rr = ad * bn;
    case (r.req_type)
      rau_pkg::REQ_ADD, rau_pkg::REQ_SUB, rau_pkg::REQ_MUL, rau_pkg::REQ_DIV: begin
        case (r.req_type)
          rau_pkg::REQ_ADD: begin n = l + rr; d = ad * bd; end
          rau_pkg::REQ_SUB: begin n = l - rr; d = ad * bd; end
          rau_pkg::REQ_MUL: begin n = an * bn; d = ad * bd; end
          default: begin n = l; d = rr; end
        endcase
        if (d == 0) begin
          o.div_zero = 1'b1;
        end else begin
          neg = (n < 0) != (d < 0);
          un  = (n < 0) ? -n : n;
          ud  = (d < 0) ? -d : d;
          if (un != 0) begin
            g  = common_divisor(un, ud);
            un = un / g;
            ud = ud / g;
          end else begin
            neg = 1'b0;
          end
          o.res_num = neg ? -un[31:0] : un[31:0];
          o.res_den = ud[30:0];
        end
      end
      rau_pkg::REQ_LT: o.cmp_true = l < rr;
      rau_pkg::REQ_LE: o.cmp_true = l <= rr;
      rau_pkg::REQ_GT: o.cmp_true = l > rr;
      rau_pkg::REQ_GE: o.cmp_true = l >= rr;
      rau_pkg::REQ_EQ: o.cmp_true = l == rr;
      rau_pkg::REQ_NE: o.cmp_true = l != rr;
      default: ;
    endcase
    return o;
  endfunction

  function automatic rau_pkg::req_t mk(logic [3:0] op, int an, int ad, int bn, int bd);
    rau_pkg::req_t r;
    r.req_type = op;
    r.a_num    = an[15:0];
    r.a_den    = ad[14:0];
    r.b_num    = bn[15:0];
    r.b_den    = bd[14:0];
    return r;
  endfunction

  function automatic rau_pkg::rsp_t rs(int n, int d, bit c, bit z);
    rau_pkg::rsp_t o;
    o.res_num  = n;
    o.res_den  = d[30:0];
    o.cmp_true = c;
    o.div_zero = z;
    return o;
  endfunction

  // random request: mostly legal denominators, now and then zero or extreme fields
  function automatic rau_pkg::req_t random_request();
    rau_pkg::req_t r;
    r.req_type = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
    r.a_num = 16'($urandom);
    r.b_num = 16'($urandom);
    r.a_den = 15'($urandom_range(1, 32767));
    r.b_den = 15'($urandom_range(1, 32767));
    case ($urandom_range(0, 9))
      0: r.a_num = 16'($urandom_range(0, 7)) - 16'd3;
      1: r.b_num = 16'($urandom_range(0, 2)) - 16'd1;
      2: begin r.a_den = 15'($urandom_range(1, 12)); r.b_den = 15'($urandom_range(1, 12)); end
      3: r.a_den = '0;
      4: r.b_den = '0;
      5: begin r.b_num = r.a_num; r.b_den = r.a_den; end
      default: ;
    endcase
    return r;
  endfunction

  // called at a falling edge; valid drops only across an idle gap
  task automatic send(rau_pkg::req_t r);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_i   <= r;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    expected_rsp_q.push_back(rational_result(r));
    @(negedge clk_i);
  endtask

  // cycle counter, ends the run on timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("rational_arithmetic_unit_tb: FAIL");
      $finish;
    end
  end

  // receiver: random stall per response, one long hold-off when asked
  initial begin
    int wait_cycles;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        stall_i <= 1'b1;
        repeat (600) @(negedge clk_i);
        hold_off = 1'b0;
      end
      wait_cycles = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) wait_cycles = 0;
      if (wait_cycles != 0) begin
        stall_i <= 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  // response check against the oldest expectation
  always @(posedge clk_i) begin
    rau_pkg::rsp_t e;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected response %p", rsp_o);
        mismatches++;
      end else begin
        e = expected_rsp_q.pop_front();
        if (rsp_o.res_num !== e.res_num) begin
          $error("res_num expected %0d actual %0d", e.res_num, rsp_o.res_num);
          mismatches++;
        end
        if (rsp_o.res_den !== e.res_den) begin
          $error("res_den expected %0d actual %0d", e.res_den, rsp_o.res_den);
          mismatches++;
        end
        if (rsp_o.cmp_true !== e.cmp_true) begin
          $error("cmp_true expected %0b actual %0b", e.cmp_true, rsp_o.cmp_true);
          mismatches++;
        end
        if (rsp_o.div_zero !== e.div_zero) begin
          $error("div_zero expected %0b actual %0b", e.div_zero, rsp_o.div_zero);
          mismatches++;
        end
      end
    end
  end

  initial begin
    vec_t v;
    // extremes, every code, zero and error cases
    dir_table.push_back('{mk(rau_pkg::REQ_ADD, 1, 2, 1, 2), 1, rs(1, 1, 0, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_SUB, 1, 3, 1, 3), 1, rs(0, 9, 0, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_MUL, -32768, 1, -32768, 1), 1,
                          rs(1073741824, 1, 0, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_MUL, 32767, 32767, 32767, 32767), 1,
                          rs(1, 1, 0, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_MUL, 0, 32767, 5, 32767), 1,
                          rs(0, 1073676289, 0, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_DIV, 3, 4, 0, 7), 1, rs(0, 0, 0, 1)});
    dir_table.push_back('{mk(rau_pkg::REQ_ADD, 3, 0, 1, 7), 1, rs(0, 0, 0, 1)});
    dir_table.push_back('{mk(rau_pkg::REQ_SUB, 3, 5, 1, 0), 1, rs(0, 0, 0, 1)});
    dir_table.push_back('{mk(rau_pkg::REQ_DIV, 1, 2, -1, 4), 1, rs(-2, 1, 0, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_DIV, -32768, 1, 32767, 1), 0, '0});
    dir_table.push_back('{mk(rau_pkg::REQ_ADD, 32767, 1, 32767, 1), 0, '0});
    dir_table.push_back('{mk(rau_pkg::REQ_SUB, -32768, 1, 32767, 1), 0, '0});
    dir_table.push_back('{mk(rau_pkg::REQ_ADD, -7, 12, 5, 18), 0, '0});
    dir_table.push_back('{mk(rau_pkg::REQ_LT, 1, 3, 1, 2), 1, rs(0, 0, 1, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_LE, 1, 2, 2, 4), 1, rs(0, 0, 1, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_GT, -1, 3, 1, 2), 1, rs(0, 0, 0, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_GE, 1, 2, 2, 4), 1, rs(0, 0, 1, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_EQ, 1, 2, 2, 4), 1, rs(0, 0, 1, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_NE, 1, 2, 2, 4), 1, rs(0, 0, 0, 0)});
    dir_table.push_back('{mk(rau_pkg::REQ_LT, 5, 0, 3, 0), 1, rs(0, 0, 0, 0)});
    dir_table.push_back('{mk(4'd10, 1, 1, 1, 1), 1, rs(0, 0, 0, 0)});
    dir_table.push_back('{mk(4'd15, -1, 32767, -1, 32767), 1, rs(0, 0, 0, 0)});

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i]) begin
      v = dir_table[i];
      if (v.typed && rational_result(v.req) != v.rsp) begin
        $error("table row %0d disagrees with predictor", i);
        mismatches++;
      end
      send(v.req);
      if (v.typed) expected_rsp_q[$] = v.rsp;
    end

    for (int i = 0; i < 1400; i++) begin
      // long receiver hold-off while requests keep coming
      if (i == 300) hold_off = 1'b1;
      send(random_request());
    end
    valid_i <= 1'b0;

    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0)
      $display("rational_arithmetic_unit_tb: PASS");
    else
      $display("rational_arithmetic_unit_tb: FAIL");
    $finish;
  end

endmodule
